// ===== hw/rtl/tlbr_pkg.sv =====
`timescale 1ns / 1ps

package tlbr_pkg;

  // Defaults for the top-level parameters
  localparam int SLOT_COUNT_DEF = 4;
  localparam int LINE_BYTES_DEF = 64;
  localparam int TERM_MAX_DEF   = 4;

  // Fixed field widths
  localparam int CHARS_W   = 32;
  localparam int COUNT_W   = 3;
  localparam int HITS_W    = 3;
  localparam int LIMIT_W   = 7;
  localparam int LEN_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int TERM_SLOTS = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TERM_CHARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 2'd1;

  // Command kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_PULL = 1'b1;

  // Pull status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_LINE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_SMALL = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH,
    ST_SEEK,
    ST_PULL_CHK,
    ST_PULL
  } tlbr_state_t;

  // Terminator configuration handed to the matcher
  typedef struct packed {
    logic [CHARS_W-1:0] chars;
    logic [COUNT_W-1:0] count;
  } tlbr_cfg_t;

  // Matcher result
  typedef struct packed {
    logic              hit;
    logic [HITS_W-1:0] active;
  } tlbr_match_t;

endpackage

// ===== hw/rtl/tlbr_ram.sv =====
`timescale 1ns / 1ps

module tlbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tlbr_term_match.sv =====
`timescale 1ns / 1ps

module tlbr_term_match #(
  parameter int TERM_MAX = 4
) (
  input  tlbr_pkg::tlbr_cfg_t   cfg,
  input  logic [7:0]            data_in,
  output tlbr_pkg::tlbr_match_t match_out
);

  import tlbr_pkg::*;

  logic [HITS_W-1:0] active;
  logic              hit;

  // Active count saturates at TERM_MAX
  assign active = (cfg.count > COUNT_W'(TERM_MAX)) ? HITS_W'(TERM_MAX) : HITS_W'(cfg.count);

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < TERM_SLOTS; k++) begin
      if ((HITS_W'(k) < active) && (cfg.chars[8*k +: 8] == data_in)) begin
        hit = 1'b1;
      end
    end
  end

  assign match_out.hit    = hit;
  assign match_out.active = active;

endmodule

// ===== hw/rtl/terminated_line_buffer_ring.sv =====
`timescale 1ns / 1ps

// Line assembler over a ring of SLOT_COUNT buffers of LINE_BYTES bytes each. A command is
// taken when start is high and busy is low. A push (in_kind 0) first takes the beat, then
// writes the byte and tests it; a push that completes a line while the writer lands on the
// reader is followed by a reader search, one slot per cycle. A pull (in_kind 1) checks the
// read slot, then copies the line through the single registered read port of the line store;
// it delivers one result beat per cycle on out_valid, the final beat flagged by out_last.
// Results are shown for exactly one cycle and cannot be held off, so the receiver must take
// every beat as it comes. After reset the line store is swept to zero, one byte a cycle, and
// the block is busy until the sweep is done; configuration writes are taken at any time,
// cfg_ready being always high, but should only be made while the block is idle.
module terminated_line_buffer_ring #(
  parameter int SLOT_COUNT = tlbr_pkg::SLOT_COUNT_DEF,
  parameter int LINE_BYTES = tlbr_pkg::LINE_BYTES_DEF,
  parameter int TERM_MAX   = tlbr_pkg::TERM_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // command channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_kind,
  input  logic [7:0]                         in_rx_byte,
  input  logic [tlbr_pkg::LIMIT_W-1:0]       in_read_limit,
  // result channel
  output logic                               out_valid,
  output logic [7:0]                         out_byte,
  output logic                               out_byte_valid,
  output logic [tlbr_pkg::LEN_W-1:0]         out_line_length,
  output logic [tlbr_pkg::STATUS_W-1:0]      out_pull_status,
  output logic                               out_last,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlbr_pkg::CHARS_W-1:0]       cfg_data
);

  import tlbr_pkg::*;

  localparam int DEPTH  = SLOT_COUNT * LINE_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int POS_W  = $clog2(LINE_BYTES + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  tlbr_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TERM_CHARS: cfg_r.chars <= cfg_data;
        REG_TERM_COUNT: cfg_r.count <= cfg_data[COUNT_W-1:0];
        default: ;  // unknown register: dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  tlbr_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [SLOT_W-1:0] read_slot_r, read_slot_nxt;
  logic [POS_W-1:0]  write_pos_r, write_pos_nxt;
  logic [HITS_W-1:0] hits_r, hits_nxt;
  logic [SLOT_COUNT-1:0] line_ready_r, line_ready_nxt;
  logic [SLOT_W-1:0] seek_cnt_r, seek_cnt_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [POS_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [HITS_W-1:0] pull_hits_r, pull_hits_nxt;

  // command payload, captured on the accepted beat
  logic [7:0]        byte_r;
  logic [POS_W-1:0]  lim_r;

  // result registers
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_bv_r, out_bv_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;
  logic                out_last_r, out_last_nxt;

  // line store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  // shared terminator matcher
  logic [7:0]  match_data;
  tlbr_match_t match;

  logic              accept;
  logic [POS_W-1:0]  pos_eff;
  logic [SLOT_W-1:0] ws_next, seek_cand;
  logic [HITS_W-1:0] hits_inc, pull_hits_inc;
  logic [ADDR_W-1:0] wr_base, rd_base;
  logic [POS_W-1:0]  rd_idx_inc;
  logic              pull_done, pull_last;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Store and matcher
  tlbr_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // push tests the incoming byte, pull tests the byte just read back
  assign match_data = (state_r == ST_PUSH) ? byte_r : ram_rdata;

  tlbr_term_match #(
    .TERM_MAX(TERM_MAX)
  ) u_match (
    .cfg      (cfg_r),
    .data_in  (match_data),
    .match_out(match)
  );

  // Slot arithmetic: base addresses and ring successors
  assign wr_base   = ADDR_W'(ADDR_W'(write_slot_r) * ADDR_W'(LINE_BYTES));
  assign rd_base   = ADDR_W'(ADDR_W'(read_slot_r) * ADDR_W'(LINE_BYTES));
  assign ws_next   = (write_slot_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : write_slot_r + 1'b1;
  assign seek_cand = (read_slot_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : read_slot_r + 1'b1;

  // a full line wraps to its start
  assign pos_eff = (write_pos_r >= POS_W'(LINE_BYTES)) ? '0 : write_pos_r;

  assign hits_inc      = hits_r + HITS_W'(match.hit);
  assign pull_hits_inc = pull_hits_r + HITS_W'(match.hit);
  assign rd_idx_inc    = rd_idx_r + 1'b1;
  assign pull_done     = match.hit && (pull_hits_inc == match.active);
  assign pull_last     = pull_done || (rd_idx_inc == lim_r);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      write_slot_r <= '0;
      read_slot_r  <= '0;
      write_pos_r  <= '0;
      hits_r       <= '0;
      line_ready_r <= '0;
      seek_cnt_r   <= '0;
      clr_addr_r   <= '0;
      rd_idx_r     <= '0;
      pull_hits_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      write_slot_r <= write_slot_nxt;
      read_slot_r  <= read_slot_nxt;
      write_pos_r  <= write_pos_nxt;
      hits_r       <= hits_nxt;
      line_ready_r <= line_ready_nxt;
      seek_cnt_r   <= seek_cnt_nxt;
      clr_addr_r   <= clr_addr_nxt;
      rd_idx_r     <= rd_idx_nxt;
      pull_hits_r  <= pull_hits_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_rx_byte;
      lim_r  <= (in_read_limit > LIMIT_W'(LINE_BYTES)) ? POS_W'(LINE_BYTES)
                                                        : POS_W'(in_read_limit);
    end
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_len_r  <= out_len_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    write_slot_nxt = write_slot_r;
    read_slot_nxt  = read_slot_r;
    write_pos_nxt  = write_pos_r;
    hits_nxt       = hits_r;
    line_ready_nxt = line_ready_r;
    seek_cnt_nxt   = seek_cnt_r;
    clr_addr_nxt   = clr_addr_r;
    rd_idx_nxt     = rd_idx_r;
    pull_hits_nxt  = pull_hits_r;

    ram_we    = 1'b0;
    ram_waddr = wr_base + ADDR_W'(pos_eff);
    ram_wdata = byte_r;
    ram_raddr = rd_base;

    out_valid_nxt = 1'b0;
    out_byte_nxt  = '0;
    out_bv_nxt    = 1'b0;
    out_len_nxt   = '0;
    out_st_nxt    = STATUS_OK;
    out_last_nxt  = 1'b0;

    unique case (state_r)
      // sweep the store to zero after reset
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_kind == KIND_PULL) ? ST_PULL_CHK : ST_PUSH;
        end
      end

      // write the byte, count terminators, close the line when the count is met
      ST_PUSH: begin
        ram_we    = 1'b1;
        state_nxt = ST_IDLE;
        if (hits_inc == match.active) begin
          line_ready_nxt[write_slot_r] = 1'b1;
          line_ready_nxt[ws_next]      = 1'b0;
          write_slot_nxt               = ws_next;
          write_pos_nxt                = '0;
          hits_nxt                     = '0;
          if (read_slot_r == ws_next) begin
            seek_cnt_nxt = '0;
            state_nxt    = ST_SEEK;
          end
        end else begin
          hits_nxt      = hits_inc;
          write_pos_nxt = pos_eff + 1'b1;
        end
      end

      // reader steps round the ring one slot a cycle looking for a ready line
      ST_SEEK: begin
        seek_cnt_nxt = seek_cnt_r + 1'b1;
        if (line_ready_r[seek_cand]) begin
          read_slot_nxt = seek_cand;
          state_nxt     = ST_IDLE;
        end else if (seek_cnt_r == SLOT_W'(SLOT_COUNT - 1)) begin
          read_slot_nxt = write_slot_r;
          state_nxt     = ST_IDLE;
        end else begin
          read_slot_nxt = seek_cand;
        end
      end

      ST_PULL_CHK: begin
        if (!line_ready_r[read_slot_r]) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = STATUS_NO_LINE;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          line_ready_nxt[read_slot_r] = 1'b0;
          if (lim_r == '0) begin
            out_valid_nxt = 1'b1;
            out_st_nxt    = STATUS_TOO_SMALL;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            // first byte's read goes out now
            ram_raddr     = rd_base;
            rd_idx_nxt    = '0;
            pull_hits_nxt = '0;
            state_nxt     = ST_PULL;
          end
        end
      end

      // one byte a beat: test the byte read back, fetch the following one
      ST_PULL: begin
        ram_raddr     = rd_base + ADDR_W'(pull_last ? rd_idx_r : rd_idx_inc);
        pull_hits_nxt = pull_hits_inc;
        rd_idx_nxt    = rd_idx_inc;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = ram_rdata;
        out_bv_nxt    = 1'b1;
        out_last_nxt  = pull_last;
        if (pull_done) begin
          out_len_nxt = LEN_W'(rd_idx_inc);
        end else if (pull_last) begin
          out_st_nxt = STATUS_TOO_SMALL;
        end
        if (pull_last) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_valid  = out_bv_r;
  assign out_line_length = out_len_r;
  assign out_pull_status = out_st_r;
  assign out_last        = out_last_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // results only come out of the pull states
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_PULL_CHK || $past(state_r) == ST_PULL))
    else $error("result beat outside a pull");

  // the line being copied has already lost its ready mark
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PULL |-> !line_ready_r[read_slot_r])
    else $error("ready mark still set during copy");

  // write position never runs past a full line
  assert property (@(posedge clk) disable iff (!rst_n)
    write_pos_r <= POS_W'(LINE_BYTES))
    else $error("write position beyond line");

  // a good line ends on a real byte with a length
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && out_pull_status == STATUS_OK)
      |-> (out_byte_valid && out_line_length != '0))
    else $error("ok status without a line");

  // an accepted push is written on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_PUSH) |=> state_r == ST_PUSH)
    else $error("push beat lost");

endmodule
